// ===== rtl/core/dfla_pkg.sv =====
`timescale 1ns / 1ps

package dfla_pkg;

    // Request kinds
    typedef enum logic
    {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    // Result status codes
    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    localparam int ADDR_W = 64;
    localparam int SLOT_W = 8;
    localparam int LEN_W  = 9;

    typedef struct packed
    {
        kind_t              kind;
        logic [ADDR_W-1:0]  buffer_address;
        logic [SLOT_W-1:0]  slot_to_free;
    } req_t;

    typedef struct packed
    {
        logic [SLOT_W-1:0]  slot_index;
        status_t            status;
    } rsp_t;

endpackage

// ===== rtl/core/dfla_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module dfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/descriptor_free_list_allocator.sv =====
`timescale 1ns / 1ps

// Descriptor slot allocator built on a linked free list. A request is taken
// on a clock edge with start high and busy low. An allocate request pops the
// head slot, records its buffer address in that slot and returns the slot
// index; a free request pushes slot_to_free back as the new head and echoes
// it. Every request produces exactly one result, shown on result for one
// cycle with done high, once the execute stage has run. The receiver
// cannot stall: sample result whenever done is high. busy is high in the
// cycle after a request is taken, so the block cannot take a new request while
// the last one executes: the link RAM's registered read of the head's next
// link must land before the head can move. An allocate on an
// empty list returns STATUS_EMPTY with slot 0 and changes nothing; a free of
// a slot at or beyond the queue length returns STATUS_RANGE and is dropped.
// Writing cfg_wdata with cfg_we sets the queue length (0 reads as 1, values
// above MAX_SLOTS saturate) and relinks the whole chain at once, head back to
// slot 0; write it only while idle. Per-entry valid bits stand in for the
// relink, so there is no clearing pass after reset or after a length write.
module descriptor_free_list_allocator
    import dfla_pkg::*;
#(
    parameter int MAX_SLOTS = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             request,
    output logic             done,
    output rsp_t             result,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata
);

    // Head and link width: holds 0..MAX_SLOTS, where a head equal to the
    // length marks the empty list.
    localparam int HW = $clog2(MAX_SLOTS + 1);
    // Only slots below 256 can ever be freed, so only those links are stored;
    // links above read as index plus one forever.
    localparam int LINK_DEPTH = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
    localparam int LAW = $clog2(LINK_DEPTH);
    // The length register tops out at 511, bounding the address store.
    localparam int ADDR_DEPTH = (MAX_SLOTS < 511) ? MAX_SLOTS : 511;
    localparam int ADW = $clog2(ADDR_DEPTH);
    localparam int LEN_RESET = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;

    logic [HW-1:0]         len_reg;
    logic [HW-1:0]         head_reg;
    logic [HW-1:0]         head_next;
    logic [LINK_DEPTH-1:0] valid_reg;
    logic                  busy_reg;
    req_t                  req_reg;
    logic                  done_reg;
    rsp_t                  result_reg;
    rsp_t                  result_next;

    logic          accept;
    logic [HW-1:0] link_q;
    logic [HW-1:0] link_val;
    logic          head_in_ram;
    logic          is_empty;
    logic          slot_ok;
    logic          link_we;
    logic          addr_we;
    logic [31:0]   len_wide;

    assign accept = start & ~busy_reg;

    // Clamp the written length into 1..MAX_SLOTS.
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            len_wide = 32'd1;
        end
        else if (32'(cfg_wdata) > 32'(MAX_SLOTS))
        begin
            len_wide = 32'(MAX_SLOTS);
        end
        else
        begin
            len_wide = 32'(cfg_wdata);
        end
    end

    // Link RAM: read the head's link at the accept edge, write on a free.
    dfla_ram #(
        .WIDTH (HW),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (req_reg.slot_to_free[LAW-1:0]),
        .wdata (head_reg),
        .raddr (head_reg[LAW-1:0]),
        .rdata (link_q)
    );

    // Buffer address store: written on each successful allocate.
    dfla_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (ADDR_DEPTH)
    ) u_addr_ram (
        .clk   (clk),
        .we    (addr_we),
        .waddr (head_reg[ADW-1:0]),
        .wdata (req_reg.buffer_address),
        .raddr ('0),
        .rdata ()
    );

    // Execute stage: the cycle after accept, with the link read back.
    always_comb
    begin
        head_in_ram = head_reg < HW'(LINK_DEPTH);
        // A link never written since the last relink reads as index plus one.
        if (head_in_ram && valid_reg[head_reg[LAW-1:0]])
        begin
            link_val = link_q;
        end
        else
        begin
            link_val = head_reg + HW'(1);
        end
        is_empty = head_reg >= len_reg;
        slot_ok  = 16'(req_reg.slot_to_free) < 16'(len_reg);

        head_next   = head_reg;
        link_we     = 1'b0;
        addr_we     = 1'b0;
        result_next = '{slot_index: '0, status: STATUS_OK};

        case (req_reg.kind)
            KIND_ALLOC:
            begin
                if (is_empty)
                begin
                    result_next.status = STATUS_EMPTY;
                end
                else
                begin
                    result_next.slot_index = SLOT_W'(head_reg);
                    head_next = link_val;
                    addr_we   = busy_reg;
                end
            end
            KIND_FREE:
            begin
                result_next.slot_index = req_reg.slot_to_free;
                if (slot_ok)
                begin
                    head_next = HW'(req_reg.slot_to_free);
                    link_we   = busy_reg;
                end
                else
                begin
                    result_next.status = STATUS_RANGE;
                end
            end
            default:
            begin
                result_next.status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= HW'(LEN_RESET);
            head_reg  <= '0;
            valid_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            // Relink: drop every stored link and restart at slot zero.
            if (cfg_we)
            begin
                len_reg   <= len_wide[HW-1:0];
                head_reg  <= '0;
                valid_reg <= '0;
            end
            else if (busy_reg)
            begin
                head_reg <= head_next;
                if (link_we)
                begin
                    valid_reg[req_reg.slot_to_free[LAW-1:0]] <= 1'b1;
                end
            end
        end
    end

    // Payload registers: hold the request and the result, no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (busy_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // A result follows a request in the execute stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding execute cycle");

    // The execute stage never holds two requests back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for two cycles");

    // The head never moves past the empty mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= len_reg)
        else $error("list head beyond queue length");

    // An exhausted allocate reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_EMPTY) |-> (result.slot_index == '0))
        else $error("empty status with nonzero slot");

endmodule
